>>> hdl/lsck_pkg.sv
// lsck_pkg: shared types, constants and hash-mix functions for the layer stack cache key block
// no dependencies; used by every module under hdl
`timescale 1ns / 1ps

package lsck_pkg;

    localparam int MAX_LAYERS_DEF = 64;

    localparam logic [63:0] MIX_CONST   = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] LOWER_SEED  = 64'd1469598103934665603;
    localparam logic [63:0] PREFIX_SEED = 64'd1099511628211;
    localparam logic [63:0] SUFFIX_SEED = 64'd7809847782465536322;
    localparam logic [7:0]  FULL_OPACITY = 8'd100;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 224;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PIX_WIDTH      = 2'd0,
        CFG_PIX_HEIGHT     = 2'd1,
        CFG_RASTER_SAMPLES = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TOO_FEW    = 2'd1,
        ST_TOP_OPAQUE = 2'd2
    } status_t;

    // one classified layer as it waits between front and back
    typedef struct packed {
        logic        effective;
        logic        opaque;
        logic [6:0]  opacity;
        logic [31:0] layer_ident;
        logic [63:0] revision;
        logic        last;
    } item_t;

    // raster dimensions as seen by the back end
    typedef struct packed {
        logic [15:0] pix_width;
        logic [15:0] pix_height;
        logic [31:0] raster_samples;
    } dims_t;

    function automatic logic [63:0] mix(input logic [63:0] k, input logic [63:0] v);
        mix = k ^ (v + MIX_CONST + (k << 6) + (k >> 2));
    endfunction

    function automatic logic [63:0] seeded(input logic [63:0] seed, input dims_t d);
        logic [63:0] k;
        k = mix(seed, {48'd0, d.pix_width});
        k = mix(k, {48'd0, d.pix_height});
        seeded = mix(k, {32'd0, d.raster_samples});
    endfunction

    function automatic logic [63:0] mix_layer(input logic [63:0] k, input logic [31:0] id,
                                              input logic [63:0] rev, input logic [6:0] op);
        logic [63:0] t;
        t = mix(k, {32'd0, id});
        t = mix(t, rev);
        mix_layer = mix(t, {57'd0, op});
    endfunction

endpackage

>>> hdl/layer_stack_cache_key.sv
// layer_stack_cache_key: top level with raster registers, front, queue and back end
// depends on lsck_pkg, lsck_front, lsck_queue, lsck_back
// an accepted word is written into the queue and hashed from the queue head into the back
// end state; a last word loads its plan word into the output register as it is read
// throughput: one layer word per cycle while the queue has room; three mixes per key per layer
// reset: synchronous active-low aresetn clears raster registers, queue, document and output state
`timescale 1ns / 1ps

module layer_stack_cache_key #(
    parameter int MAX_LAYERS = lsck_pkg::MAX_LAYERS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [lsck_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lsck_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // layer words in, bottom layer first
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // fields from bit 0: visible, has_opacity, opacity_percent[7:0], raster_ok,
    // revision_ok, layer_ident[31:0], revision[63:0], zero pad
    input  logic [lsck_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tlast,   // top layer of the document
    // plan words out
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // fields from bit 0: status[1:0], used_layers[6:0], run_start[6:0],
    // run_length[6:0], has_partial_run, lower_key[63:0], prefix_valid,
    // prefix_key[63:0], suffix_valid, suffix_key[63:0], zero pad
    output logic [lsck_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // a plan word is produced only on a word with tlast; it waits in the output register
    // no clearing pass; keys are reseeded from the raster registers at every document start

    lsck_pkg::dims_t dims_reg;

    logic            q_full;
    logic            q_wr_en;
    lsck_pkg::item_t q_wr_item;
    logic            q_rd_en;
    logic            q_valid;
    lsck_pkg::item_t q_item;

    // raster registers; writes to an unused index are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lsck_pkg::CFG_PIX_WIDTH: begin
                    dims_reg.pix_width <= cfg_wdata[15:0];
                end
                lsck_pkg::CFG_PIX_HEIGHT: begin
                    dims_reg.pix_height <= cfg_wdata[15:0];
                end
                lsck_pkg::CFG_RASTER_SAMPLES: begin
                    dims_reg.raster_samples <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // front: unpack, clamp opacity, classify effective and opaque layers
    lsck_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .q_wr_en   (q_wr_en),
        .q_wr_item (q_wr_item)
    );

    // two entries keep the input open while the back end holds a plan word
    lsck_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_wr_en),
        .wr_item  (q_wr_item),
        .full     (q_full),
        .rd_en    (q_rd_en),
        .rd_valid (q_valid),
        .rd_item  (q_item)
    );

    // back: lower, prefix and suffix chains plus the plan word register
    lsck_back #(
        .MAX_LAYERS (MAX_LAYERS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .dims     (dims_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_rd_en  (q_rd_en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> hdl/lsck_front.sv
// lsck_front: unpacks an input word, clamps opacity and classifies the layer
// depends on lsck_pkg; feeds lsck_queue
`timescale 1ns / 1ps

module lsck_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lsck_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           q_full,
    output logic                           q_wr_en,
    output lsck_pkg::item_t                q_wr_item
);

    logic       visible;
    logic       has_opacity;
    logic [7:0] opacity_in;
    logic       raster_ok;
    logic       revision_ok;
    logic [7:0] opacity;

    assign visible     = s_tdata[0];
    assign has_opacity = s_tdata[1];
    assign opacity_in  = s_tdata[9:2];
    assign raster_ok   = s_tdata[10];
    assign revision_ok = s_tdata[11];

    always_comb begin
        if (!has_opacity) begin
            opacity = lsck_pkg::FULL_OPACITY;
        end else if (opacity_in > lsck_pkg::FULL_OPACITY) begin
            opacity = lsck_pkg::FULL_OPACITY;
        end else begin
            opacity = opacity_in;
        end
    end

    always_comb begin
        q_wr_item.effective   = visible && raster_ok && (opacity != 8'd0);
        q_wr_item.opaque      = (opacity == lsck_pkg::FULL_OPACITY);
        q_wr_item.opacity     = opacity[6:0];
        q_wr_item.layer_ident = s_tdata[43:12];
        q_wr_item.revision    = revision_ok ? s_tdata[107:44] : 64'd0;
        q_wr_item.last        = s_tlast;
    end

    assign s_tready = !q_full;
    assign q_wr_en  = s_tvalid && !q_full;

endmodule

>>> hdl/lsck_queue.sv
// lsck_queue: two-entry queue of classified layers between front and back
// depends on lsck_pkg
`timescale 1ns / 1ps

module lsck_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  lsck_pkg::item_t wr_item,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_valid,
    output lsck_pkg::item_t rd_item
);

    lsck_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = entry_reg[rd_ptr_reg];

endmodule

>>> hdl/lsck_back.sv
// lsck_back: runs the three hash chains per layer and builds the plan word
// depends on lsck_pkg; drains lsck_queue and drives the result channel
`timescale 1ns / 1ps

module lsck_back #(
    parameter int MAX_LAYERS = lsck_pkg::MAX_LAYERS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  lsck_pkg::dims_t                  dims,
    input  logic                             q_valid,
    input  lsck_pkg::item_t                  q_item,
    output logic                             q_rd_en,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lsck_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int CNT_W = $clog2(MAX_LAYERS + 1);

    // seeds are registered from the raster registers and follow them in the next cycle
    logic [63:0] seed_lower_reg, seed_prefix_reg, seed_suffix_reg;

    logic              doc_open_reg, doc_open_next;
    logic [63:0]       lower_running_reg, lower_running_next;
    logic [63:0]       lower_snapshot_reg, lower_snapshot_next;
    logic [63:0]       prefix_running_reg, prefix_running_next;
    logic [63:0]       prefix_before_top_reg, prefix_before_top_next;
    logic [63:0]       suffix_running_reg, suffix_running_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  boundary_reg, boundary_next;
    logic              top_opaque_reg, top_opaque_next;

    logic [63:0]      cur_lower, cur_snapshot, cur_prefix, cur_before_top, cur_suffix;
    logic [CNT_W-1:0] cur_count, cur_boundary, run;
    logic             cur_top_opaque;
    logic             take;
    logic [63:0]      lower_mixed, prefix_mixed, suffix_mixed;

    logic [CNT_W+6:0] count_ext, boundary_ext, run_ext;
    logic                            out_load;
    logic                            out_valid_reg, out_valid_next;
    logic [lsck_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    lsck_pkg::status_t status;
    logic              wide;
    logic [63:0]       prefix_key, suffix_key, lower_key;
    logic [6:0]        run_start_f, run_length_f;
    logic              has_partial;

    always_ff @(posedge aclk) begin
        seed_lower_reg  <= lsck_pkg::seeded(lsck_pkg::LOWER_SEED, dims);
        seed_prefix_reg <= lsck_pkg::seeded(lsck_pkg::PREFIX_SEED, dims);
        seed_suffix_reg <= lsck_pkg::seeded(lsck_pkg::SUFFIX_SEED, dims);
    end

    // a closed document reads as freshly seeded state
    always_comb begin
        cur_lower      = doc_open_reg ? lower_running_reg : seed_lower_reg;
        cur_snapshot   = doc_open_reg ? lower_snapshot_reg : seed_lower_reg;
        cur_prefix     = doc_open_reg ? prefix_running_reg : seed_prefix_reg;
        cur_before_top = doc_open_reg ? prefix_before_top_reg : seed_prefix_reg;
        cur_suffix     = doc_open_reg ? suffix_running_reg : seed_suffix_reg;
        cur_count      = doc_open_reg ? count_reg : '0;
        cur_boundary   = doc_open_reg ? boundary_reg : '0;
        cur_top_opaque = doc_open_reg ? top_opaque_reg : 1'b0;
    end

    always_comb begin
        lower_mixed  = lsck_pkg::mix_layer(cur_lower, q_item.layer_ident, q_item.revision,
                                           q_item.opacity);
        prefix_mixed = lsck_pkg::mix_layer(cur_prefix, q_item.layer_ident, q_item.revision,
                                           q_item.opacity);
        suffix_mixed = lsck_pkg::mix_layer(cur_suffix, q_item.layer_ident, q_item.revision,
                                           q_item.opacity);
        take = q_item.effective && (cur_count < CNT_W'(MAX_LAYERS));
    end

    always_comb begin
        lower_running_next     = cur_lower;
        lower_snapshot_next    = cur_snapshot;
        prefix_running_next    = cur_prefix;
        prefix_before_top_next = cur_before_top;
        suffix_running_next    = cur_suffix;
        count_next             = cur_count;
        boundary_next          = cur_boundary;
        top_opaque_next        = cur_top_opaque;
        if (take) begin
            prefix_before_top_next = cur_prefix;
            prefix_running_next    = prefix_mixed;
            lower_running_next     = lower_mixed;
            count_next             = cur_count + CNT_W'(1);
            if (q_item.opaque) begin
                lower_snapshot_next = lower_mixed;
                suffix_running_next = seed_suffix_reg;
                boundary_next       = cur_count + CNT_W'(1);
                top_opaque_next     = 1'b1;
            end else begin
                suffix_running_next = suffix_mixed;
                top_opaque_next     = 1'b0;
            end
        end
        doc_open_next = !q_item.last;
    end

    // a last layer waits until the output register can take its word
    assign q_rd_en  = q_valid && (!q_item.last || !out_valid_reg || m_tready);
    assign out_load = q_rd_en && q_item.last;

    always_comb begin
        run          = count_next - boundary_next;
        count_ext    = {7'd0, count_next};
        boundary_ext = {7'd0, boundary_next};
        run_ext      = {7'd0, run};
        wide         = (run >= CNT_W'(2));
        if (count_next < CNT_W'(2)) begin
            status = lsck_pkg::ST_TOO_FEW;
        end else if (top_opaque_next) begin
            status = lsck_pkg::ST_TOP_OPAQUE;
        end else begin
            status = lsck_pkg::ST_OK;
        end
        run_start_f  = 7'd0;
        run_length_f = 7'd0;
        has_partial  = 1'b0;
        lower_key    = 64'd0;
        prefix_key   = 64'd0;
        suffix_key   = 64'd0;
        if (status == lsck_pkg::ST_OK) begin
            run_start_f  = boundary_ext[6:0];
            run_length_f = run_ext[6:0];
            has_partial  = (run != '0);
            lower_key    = lower_snapshot_next;
            if (wide) begin
                prefix_key = lsck_pkg::mix(prefix_before_top_next, lower_snapshot_next);
                suffix_key = suffix_running_next;
            end
        end else begin
            wide = 1'b0;
        end
        out_data_next = {6'd0, suffix_key, wide, prefix_key, wide, lower_key, has_partial,
                         run_length_f, run_start_f, count_ext[6:0], status};
    end

    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            doc_open_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            count_reg      <= '0;
            boundary_reg   <= '0;
            top_opaque_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (q_rd_en) begin
                doc_open_reg   <= doc_open_next;
                count_reg      <= count_next;
                boundary_reg   <= boundary_next;
                top_opaque_reg <= top_opaque_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_rd_en) begin
            lower_running_reg     <= lower_running_next;
            lower_snapshot_reg    <= lower_snapshot_next;
            prefix_running_reg    <= prefix_running_next;
            prefix_before_top_reg <= prefix_before_top_next;
            suffix_running_reg    <= suffix_running_next;
        end
        if (out_load) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> tb/tb.sv
// tb: self-checking bench for layer_stack_cache_key, layer words in and plan words out
// depends on lsck_pkg for the raster register indexes, status codes and hash constants
`timescale 1ns / 1ps

module tb;

    localparam int STACK_DEPTH    = lsck_pkg::MAX_LAYERS_DEF;
    localparam int LIMIT_CYCLES   = 500000;
    localparam int DRAIN_CYCLES   = 8;      // extra wait after the last outstanding plan word is taken
    localparam int RX_HOLD_CYCLES = 400;
    localparam int PHASE_WORDS    = 160;

    // input word fields, msb first so that bit 0 is visible
    typedef struct packed {
        logic [63:0] revision;
        logic [31:0] layer_ident;
        logic        revision_ok;
        logic        raster_ok;
        logic [7:0]  opacity_percent;
        logic        has_opacity;
        logic        visible;
    } layer_t;

    // plan word fields, msb first so that bit 0 is status
    typedef struct packed {
        logic [63:0]       suffix_key;
        logic              suffix_valid;
        logic [63:0]       prefix_key;
        logic              prefix_valid;
        logic [63:0]       lower_key;
        logic              has_partial_run;
        logic [6:0]        run_length;
        logic [6:0]        run_start;
        logic [6:0]        used_layers;
        lsck_pkg::status_t status;
    } plan_t;

    localparam int LAYER_W = $bits(layer_t);
    localparam int PLAN_W  = $bits(plan_t);

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [lsck_pkg::CFG_INDEX_W-1:0] cfg_index = lsck_pkg::CFG_PIX_WIDTH;
    logic [lsck_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    // visible, has_opacity, opacity_percent[7:0], raster_ok, revision_ok,
    // layer_ident[31:0], revision[63:0], zero pad
    logic [lsck_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                             s_tlast   = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    // status[1:0], used_layers[6:0], run_start[6:0], run_length[6:0],
    // has_partial_run, lower_key[63:0], prefix_valid, prefix_key[63:0],
    // suffix_valid, suffix_key[63:0], zero pad
    logic [lsck_pkg::OUT_TDATA_W-1:0] m_tdata;

    layer_stack_cache_key #(
        .MAX_LAYERS(STACK_DEPTH)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // key predictor: raster register copies and running document state
    // ------------------------------------------------------------------
    logic [15:0] dim_width   = '0;
    logic [15:0] dim_height  = '0;
    logic [31:0] dim_samples = '0;

    logic [63:0] acc_lower, lower_at_opaque;
    logic [63:0] acc_prefix, prefix_below_top;
    logic [63:0] acc_suffix;
    int          taken_count  = 0;
    int          opaque_mark  = 0;   // layers up to and including the topmost opaque one
    bit          top_opaque   = 1'b0;
    bit          doc_active   = 1'b0;

    plan_t       expected_plans[$];
    int          mismatches = 0;

    // idling controls shared by the test tasks and the two handshake sides
    bit          tx_gaps_on  = 1'b0;
    bit          rx_stalls_on = 1'b0;
    int          hold_req    = 0;    // bumped by a test to ask for a long receiver hold

    function automatic logic [63:0] fold(input logic [63:0] k, input logic [63:0] v);
        return k ^ (v + lsck_pkg::MIX_CONST + (k << 6) + (k >> 2));
    endfunction

    function automatic logic [63:0] seed_key(input logic [63:0] seed);
        logic [63:0] k;
        k = fold(seed, {48'd0, dim_width});
        k = fold(k, {48'd0, dim_height});
        return fold(k, {32'd0, dim_samples});
    endfunction

    function automatic logic [63:0] fold_layer(input logic [63:0] k, input logic [31:0] id,
                                               input logic [63:0] rev, input logic [7:0] op);
        logic [63:0] t;
        t = fold(k, {32'd0, id});
        t = fold(t, rev);
        return fold(t, {56'd0, op});
    endfunction

    // advance the document state by one layer; a plan comes out on the top layer
    function automatic void absorb_layer(input layer_t l, input bit is_top,
                                         output bit has_plan, output plan_t p);
        logic [7:0]  op;
        logic [63:0] rev;
        int          run;
        if (!doc_active) begin
            // keys reseeded from the registers as they stand at the first layer
            acc_lower        = seed_key(lsck_pkg::LOWER_SEED);
            lower_at_opaque  = acc_lower;
            acc_prefix       = seed_key(lsck_pkg::PREFIX_SEED);
            prefix_below_top = acc_prefix;
            acc_suffix       = seed_key(lsck_pkg::SUFFIX_SEED);
            taken_count      = 0;
            opaque_mark      = 0;
            top_opaque       = 1'b0;
            doc_active       = 1'b1;
        end
        if (!l.has_opacity)
            op = lsck_pkg::FULL_OPACITY;
        else if (l.opacity_percent > lsck_pkg::FULL_OPACITY)
            op = lsck_pkg::FULL_OPACITY;
        else
            op = l.opacity_percent;
        rev = l.revision_ok ? l.revision : 64'd0;

        // layers past the stack depth are neither counted nor hashed
        if (l.visible && op != 8'd0 && l.raster_ok && taken_count < STACK_DEPTH) begin
            prefix_below_top = acc_prefix;
            acc_prefix  = fold_layer(acc_prefix, l.layer_ident, rev, op);
            acc_lower   = fold_layer(acc_lower, l.layer_ident, rev, op);
            taken_count = taken_count + 1;
            if (op == lsck_pkg::FULL_OPACITY) begin
                lower_at_opaque = acc_lower;
                acc_suffix      = seed_key(lsck_pkg::SUFFIX_SEED);
                opaque_mark     = taken_count;
                top_opaque      = 1'b1;
            end else begin
                acc_suffix = fold_layer(acc_suffix, l.layer_ident, rev, op);
                top_opaque = 1'b0;
            end
        end

        has_plan = is_top;
        p = '0;
        if (!is_top)
            return;
        p.used_layers = taken_count[6:0];
        if (taken_count < 2) begin
            p.status = lsck_pkg::ST_TOO_FEW;
        end else if (top_opaque) begin
            p.status = lsck_pkg::ST_TOP_OPAQUE;
        end else begin
            run               = taken_count - opaque_mark;
            p.status          = lsck_pkg::ST_OK;
            p.run_start       = opaque_mark[6:0];
            p.run_length      = run[6:0];
            p.has_partial_run = (run > 0);
            p.lower_key       = lower_at_opaque;
            // a run of one layer gets no prefix or suffix key
            if (run >= 2) begin
                p.prefix_valid = 1'b1;
                p.prefix_key   = fold(prefix_below_top, lower_at_opaque);
                p.suffix_valid = 1'b1;
                p.suffix_key   = acc_suffix;
            end
        end
        doc_active = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // idle length: mostly short, now and then a long stretch
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic layer_t make_layer(input bit vis, input bit has_op, input logic [7:0] op,
                                          input bit rok, input bit revok,
                                          input logic [31:0] id, input logic [63:0] rev);
        layer_t l;
        l.visible         = vis;
        l.has_opacity     = has_op;
        l.opacity_percent = op;
        l.raster_ok       = rok;
        l.revision_ok     = revok;
        l.layer_ident     = id;
        l.revision        = rev;
        return l;
    endfunction

    // random layer; the flags bias it toward an opaque base or a partial top
    function automatic layer_t random_layer(input bit want_opaque, input bit want_partial);
        layer_t l;
        int     r;
        l.visible         = ($urandom_range(0, 15) != 0);
        l.raster_ok       = ($urandom_range(0, 15) != 0);
        l.revision_ok     = ($urandom_range(0, 3) != 0);
        l.layer_ident     = $urandom;
        l.revision        = {$urandom, $urandom};
        l.has_opacity     = 1'b1;
        l.opacity_percent = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (want_opaque) begin
            l.visible         = 1'b1;
            l.raster_ok       = 1'b1;
            l.has_opacity     = 1'($urandom_range(0, 1));
            l.opacity_percent = 8'($urandom_range(100, 255));
        end else if (want_partial && r < 85) begin
            l.visible         = 1'b1;
            l.raster_ok       = 1'b1;
            l.opacity_percent = 8'($urandom_range(1, 99));
        end else if (r < 45) begin
            l.opacity_percent = 8'($urandom_range(1, 99));
        end else if (r < 60) begin
            l.has_opacity = 1'b0;       // percent bits ignored, still toggled
        end else if (r < 72) begin
            l.opacity_percent = 8'($urandom_range(100, 255));
        end else if (r < 80) begin
            l.opacity_percent = 8'd0;
        end
        return l;
    endfunction

    // offer one layer word, wait for the handshake, then predict it
    task automatic send_layer(input layer_t l, input bit is_top);
        int    gap;
        bit    has_plan;
        plan_t p;
        gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? idle_length() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(lsck_pkg::IN_TDATA_W - LAYER_W){1'b0}}, l};
        s_tlast  <= is_top;
        do
            @(posedge aclk);
        while (!s_tready);
        absorb_layer(l, is_top, has_plan, p);
        if (has_plan)
            expected_plans.push_back(p);
    endtask

    // random document of n layers, top layer flagged last
    task automatic send_document(input int n);
        bit base_opaque;
        base_opaque = 1'($urandom_range(0, 1));
        for (int i = 0; i < n; i++)
            send_layer(random_layer(i == 0 && base_opaque,
                                    i == n - 1 && $urandom_range(0, 4) != 0), i == n - 1);
    endtask

    function automatic int doc_length();
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 8);
        return $urandom_range(9, 24);
    endfunction

    // stop offering, wait for every outstanding plan word, let the pipe settle
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (expected_plans.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input lsck_pkg::cfg_index_t idx, input logic [31:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            lsck_pkg::CFG_PIX_WIDTH:      dim_width   = value[15:0];
            lsck_pkg::CFG_PIX_HEIGHT:     dim_height  = value[15:0];
            lsck_pkg::CFG_RASTER_SAMPLES: dim_samples = value;
            default: ;
        endcase
    endtask

    // registers only change with the block idle between documents
    task automatic set_raster(input logic [31:0] w, input logic [31:0] h,
                              input logic [31:0] n);
        wait_drained();
        write_reg(lsck_pkg::CFG_PIX_WIDTH, w);
        write_reg(lsck_pkg::CFG_PIX_HEIGHT, h);
        write_reg(lsck_pkg::CFG_RASTER_SAMPLES, n);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic apply_reset();
        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    endtask

    // hand-picked documents under the reset register values
    task automatic test_directed_docs();
        // single opaque layer with zero ident and revision: too few layers
        send_layer(make_layer(1'b1, 1'b0, 8'd0, 1'b1, 1'b1, 32'd0, 64'd0), 1'b1);
        // only an invisible layer: nothing counted
        send_layer(make_layer(1'b0, 1'b1, 8'd50, 1'b1, 1'b1, 32'h1, 64'h2), 1'b1);
        // opaque base, one partial layer on top: run of one, no prefix or suffix
        send_layer(make_layer(1'b1, 1'b1, 8'd100, 1'b1, 1'b1, 32'h10, 64'h20), 1'b0);
        send_layer(make_layer(1'b1, 1'b1, 8'd50, 1'b1, 1'b1, 32'h11, 64'h21), 1'b1);
        // clamped opaque base at all-ones fields, zero opacity, bad raster,
        // missing revision, then a partial run of three
        send_layer(make_layer(1'b1, 1'b1, 8'd255, 1'b1, 1'b1, 32'hffff_ffff,
                              64'hffff_ffff_ffff_ffff), 1'b0);
        send_layer(make_layer(1'b1, 1'b1, 8'd0, 1'b1, 1'b1, 32'h20, 64'h30), 1'b0);
        send_layer(make_layer(1'b1, 1'b1, 8'd30, 1'b0, 1'b1, 32'h21, 64'h31), 1'b0);
        send_layer(make_layer(1'b1, 1'b1, 8'd1, 1'b1, 1'b0, 32'h22,
                              64'hdead_beef_0123_4567), 1'b0);
        send_layer(make_layer(1'b1, 1'b1, 8'd99, 1'b1, 1'b1, 32'h23, 64'h33), 1'b0);
        send_layer(make_layer(1'b1, 1'b1, 8'd7, 1'b1, 1'b1, 32'h24, 64'h34), 1'b1);
        // partial under an opaque top: top opaque status
        send_layer(make_layer(1'b1, 1'b1, 8'd40, 1'b1, 1'b1, 32'h30, 64'h40), 1'b0);
        send_layer(make_layer(1'b1, 1'b0, 8'd13, 1'b1, 1'b1, 32'h31, 64'h41), 1'b1);
        // no opaque layer at all: run starts at zero, lower key is the bare seed
        send_layer(make_layer(1'b1, 1'b1, 8'd10, 1'b1, 1'b1, 32'h40, 64'h50), 1'b0);
        send_layer(make_layer(1'b1, 1'b1, 8'd20, 1'b1, 1'b1, 32'h41, 64'h51), 1'b0);
        send_layer(make_layer(1'b1, 1'b1, 8'd30, 1'b1, 1'b1, 32'h42, 64'h52), 1'b1);
        // last word is not effective itself; plan still closes on it
        send_layer(make_layer(1'b1, 1'b1, 8'd60, 1'b1, 1'b1, 32'h50, 64'h60), 1'b0);
        send_layer(make_layer(1'b1, 1'b1, 8'd70, 1'b1, 1'b1, 32'h51, 64'h61), 1'b0);
        send_layer(make_layer(1'b0, 1'b1, 8'd80, 1'b1, 1'b1, 32'h52, 64'h62), 1'b1);
    endtask

    // register extremes and single-register settings, a couple of documents each
    task automatic test_raster_registers();
        logic [31:0] w [7];
        logic [31:0] h [7];
        logic [31:0] n [7];
        w = '{32'hffff, 32'h0, 32'h1, 32'h0, 32'h0, $urandom, $urandom};
        h = '{32'hffff, 32'h0, 32'h0, 32'hffff, 32'h0, $urandom, $urandom};
        n = '{32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'h1, $urandom, $urandom};
        for (int s = 0; s < 7; s++) begin
            set_raster(w[s], h[s], n[s]);
            send_document($urandom_range(2, 6));
            send_document($urandom_range(2, 6));
        end
    endtask

    // documents deeper than the stack and exactly at its depth: extra layers are dropped
    task automatic test_stack_overflow();
        set_raster($urandom, $urandom, $urandom);
        // opaque base, partial body, opaque layers past the limit with the top one
        for (int i = 0; i < STACK_DEPTH + 6; i++)
            send_layer(make_layer(1'b1, 1'b1, (i == 0 || i >= STACK_DEPTH) ? 8'd100 : 8'd55,
                                  1'b1, 1'b1, $urandom, {$urandom, $urandom}),
                       i == STACK_DEPTH + 5);
        // exactly the stack depth of random layers
        for (int i = 0; i < STACK_DEPTH; i++)
            send_layer(random_layer(i == 0, 1'b1), i == STACK_DEPTH - 1);
        wait_drained();
    endtask

    // long receiver hold while the sender streams short documents back to back
    task automatic test_output_backpressure();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        hold_req     = hold_req + 1;
        for (int d = 0; d < 30; d++)
            send_document(2);
        // sender pauses until every plan word is out
        wait_drained();
    endtask

    // random documents in phases, each under fresh register values
    task automatic test_random_docs();
        int sent;
        int n;
        for (int ph = 0; ph < 4; ph++) begin
            set_raster($urandom, $urandom, $urandom);
            // first phase runs at full rate on both sides
            tx_gaps_on   = (ph != 0);
            rx_stalls_on = (ph != 0);
            sent = 0;
            while (sent < PHASE_WORDS) begin
                n = doc_length();
                send_document(n);
                sent = sent + n;
            end
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls plus the long hold asked for by a test
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : plan_receiver
        int hold_seen;
        int hold_left;
        int stall_left;
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = RX_HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
            stall_left = idle_length() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // checker: every accepted plan word against the oldest prediction
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
                $display("plan %s: expected %h, got %h", name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : plan_check
        plan_t got;
        plan_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = plan_t'(m_tdata[PLAN_W-1:0]);
            if (expected_plans.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("plan word with nothing pending: %h", m_tdata);
            end else begin
                want = expected_plans.pop_front();
                check_field("status", 64'(want.status), 64'(got.status));
                check_field("used_layers", 64'(want.used_layers), 64'(got.used_layers));
                check_field("run_start", 64'(want.run_start), 64'(got.run_start));
                check_field("run_length", 64'(want.run_length), 64'(got.run_length));
                check_field("has_partial_run", 64'(want.has_partial_run),
                            64'(got.has_partial_run));
                check_field("lower_key", want.lower_key, got.lower_key);
                check_field("prefix_valid", 64'(want.prefix_valid), 64'(got.prefix_valid));
                check_field("prefix_key", want.prefix_key, got.prefix_key);
                check_field("suffix_valid", 64'(want.suffix_valid), 64'(got.suffix_valid));
                check_field("suffix_key", want.suffix_key, got.suffix_key);
            end
        end
    end

    // run limit well above the slowest correct run
    always @(posedge aclk) begin : run_limit
        int cycles;
        cycles = cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        apply_reset();
        test_directed_docs();
        test_raster_registers();
        test_stack_overflow();
        test_output_backpressure();
        test_random_docs();
        wait_drained();
        if (mismatches == 0 && expected_plans.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
